FILE: rtl/calm_pkg.sv
// shared constants and types for the current average limit monitor
package calm_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int SHIFT       = 4;
	localparam int WINDOW      = 1 << SHIFT;
	localparam int POS_BITS    = SHIFT;
	localparam int SUM_BITS    = SAMPLE_BITS + SHIFT;
	localparam int REG_BITS    = 10;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_BITS-1:0]    sum_t;
	typedef logic [POS_BITS-1:0]    pos_t;
	typedef logic [REG_BITS-1:0]    reg_t;

	typedef enum logic [0:0] {
		REG_CURRENT_LIMIT    = 1'b0,
		REG_LIMIT_HYSTERESIS = 1'b1
	} reg_index_t;

endpackage

FILE: rtl/calm_window.sv
// sample ring and running window sum for the boxcar average
module calm_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  calm_pkg::sample_t sample,
	output calm_pkg::sum_t    sum_next
);
	import calm_pkg::*;

	sample_t ring_q [WINDOW];
	pos_t    pos_q;
	sum_t    sum_q;
	pos_t    pos_next;

	always_comb begin
		if (pos_q == pos_t'(WINDOW - 1)) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + pos_t'(1);
		end
		sum_next = sum_q - sum_t'(ring_q[pos_next]) + sum_t'(sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			for (int k = 0; k < WINDOW; k++) begin
				ring_q[k] <= '0;
			end
		end else if (advance) begin
			pos_q            <= pos_next;
			sum_q            <= sum_next;
			ring_q[pos_next] <= sample;
		end
	end

endmodule

FILE: rtl/current_avg_limit_monitor_core.sv
// top level of the motor current average and limit monitor
// a request waits in the input register, then its result in the output register
// one request per cycle without out_stall, set by the single ring write and sum update
// an input register and an output register allow a new request while a result waits
// reset clears the sample ring, window sum, ring position, limit flag and both valid bits
module current_avg_limit_monitor_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  calm_pkg::sample_t      current_sample,
	input  logic                   enable_a_level,
	input  logic                   enable_b_level,
	output logic                   out_valid,
	input  logic                   out_stall,
	output calm_pkg::sample_t      average_current,
	output logic                   limit_active,
	output logic                   fault_a,
	output logic                   fault_b,
	output logic                   fault_any,
	input  logic                   wr_en,
	input  calm_pkg::reg_index_t   wr_index,
	input  calm_pkg::reg_t         wr_data
);
	import calm_pkg::*;

	reg_t    current_limit_q;
	reg_t    limit_hysteresis_q;

	logic    valid_s1;
	sample_t sample_s1;
	logic    ena_s1;
	logic    enb_s1;

	logic    flag_q;
	logic    out_valid_q;
	sample_t avg_q;
	logic    lim_q;
	logic    fa_q;
	logic    fb_q;

	logic    out_ready;
	logic    advance;
	sum_t    sum_next;
	sample_t avg;
	reg_t    release_th;
	logic    flag_next;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_limit_q    <= '0;
			limit_hysteresis_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CURRENT_LIMIT:    current_limit_q    <= wr_data;
				REG_LIMIT_HYSTERESIS: limit_hysteresis_q <= wr_data;
				default:              ;
			endcase
		end
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= current_sample;
			ena_s1    <= enable_a_level;
			enb_s1    <= enable_b_level;
		end
	end

	calm_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.sample   (sample_s1),
		.sum_next (sum_next)
	);

	// average and hysteresis limit
	always_comb begin
		avg        = sum_next[SUM_BITS-1:SHIFT];
		release_th = (current_limit_q > limit_hysteresis_q) ?
			(current_limit_q - limit_hysteresis_q) : '0;
		flag_next  = flag_q;
		if (current_limit_q != '0) begin
			if (avg > current_limit_q) begin
				flag_next = 1'b1;
			end
			if (flag_next && (avg < release_th)) begin
				flag_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flag_q <= flag_next;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			avg_q <= avg;
			lim_q <= flag_next;
			fa_q  <= !ena_s1;
			fb_q  <= !enb_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign average_current = avg_q;
	assign limit_active    = lim_q;
	assign fault_a         = fa_q;
	assign fault_b         = fb_q;
	assign fault_any       = fa_q | fb_q | lim_q;

endmodule

FILE: tb/current_avg_limit_monitor_core_tb.sv
// self-checking testbench for the current average limit monitor core
module current_avg_limit_monitor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import calm_pkg::*;

	typedef struct {
		sample_t average;
		logic    limit;
		logic    fault_a;
		logic    fault_b;
		logic    fault_any;
	} monitor_reading_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	sample_t    current_sample;
	logic       enable_a_level;
	logic       enable_b_level;
	logic       out_valid;
	logic       out_stall;
	sample_t    average_current;
	logic       limit_active;
	logic       fault_a;
	logic       fault_b;
	logic       fault_any;
	logic       wr_en;
	reg_index_t wr_index;
	reg_t       wr_data;

	// predictor state
	sample_t window_ring [WINDOW];
	pos_t    newest_pos;
	sum_t    running_sum;
	logic    over_limit;
	reg_t    limit_reg;
	reg_t    hysteresis_reg;

	monitor_reading_t pending_readings[$];
	int mismatch_count = 0;
	bit no_idle = 1'b0;
	int hold_off_cycles = 0;

	current_avg_limit_monitor_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.current_sample  (current_sample),
		.enable_a_level  (enable_a_level),
		.enable_b_level  (enable_b_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.average_current (average_current),
		.limit_active    (limit_active),
		.fault_a         (fault_a),
		.fault_b         (fault_b),
		.fault_any       (fault_any),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data)
	);

	always #5 clk = ~clk;

	function automatic monitor_reading_t predict_reading(sample_t sample, logic ena, logic enb);
		monitor_reading_t r;
		reg_t release_level;
		newest_pos = newest_pos + pos_t'(1);
		running_sum = running_sum - sum_t'(window_ring[newest_pos]) + sum_t'(sample);
		window_ring[newest_pos] = sample;
		r.average = sample_t'(running_sum >> SHIFT);
		if (limit_reg != '0) begin
			if (r.average > limit_reg)
				over_limit = 1'b1;
			release_level = (limit_reg > hysteresis_reg) ? limit_reg - hysteresis_reg : '0;
			if (over_limit && r.average < release_level)
				over_limit = 1'b0;
		end
		r.limit = over_limit;
		r.fault_a = ~ena;
		r.fault_b = ~enb;
		r.fault_any = r.fault_a | r.fault_b | r.limit;
		return r;
	endfunction

	task automatic send_sample(sample_t sample, logic ena, logic enb);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		current_sample <= sample;
		enable_a_level <= ena;
		enable_b_level <= enb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_readings.push_back(predict_reading(sample, ena, enb));
	endtask

	task automatic wait_drained();
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, reg_t data);
		in_valid <= 1'b0;
		wait_drained();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_CURRENT_LIMIT)
			limit_reg = data;
		else
			hysteresis_reg = data;
	endtask

	task automatic report_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// receiver: random stalls, long hold-off on demand, checks every accepted result
	initial begin
		int n;
		monitor_reading_t exp_r;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_readings.size() == 0) begin
				$display("%0t: result with no request pending, expected none actual average %0d",
					$time, average_current);
				mismatch_count++;
			end else begin
				exp_r = pending_readings.pop_front();
				report_field("average_current", 32'(exp_r.average), 32'(average_current));
				report_field("limit_active", 32'(exp_r.limit), 32'(limit_active));
				report_field("fault_a", 32'(exp_r.fault_a), 32'(fault_a));
				report_field("fault_b", 32'(exp_r.fault_b), 32'(fault_b));
				report_field("fault_any", 32'(exp_r.fault_any), 32'(fault_any));
			end
		end
	end

	task automatic test_fault_pins();
		send_sample(10'd0, 1'b1, 1'b1);
		send_sample(10'd1023, 1'b0, 1'b1);
		send_sample(10'h155, 1'b1, 1'b0);
		send_sample(10'h2AA, 1'b0, 1'b0);
	endtask

	task automatic test_limit_directed();
		// hysteresis above limit: release threshold saturates at zero
		write_reg(REG_CURRENT_LIMIT, 10'd60);
		write_reg(REG_LIMIT_HYSTERESIS, 10'd1023);
		send_sample(10'd1023, 1'b1, 1'b1);
		send_sample(10'd1023, 1'b1, 1'b1);
		send_sample(10'd0, 1'b1, 1'b1);
		// limit disabled: flag holds
		write_reg(REG_CURRENT_LIMIT, 10'd0);
		send_sample(10'd0, 1'b1, 1'b1);
		send_sample(10'd0, 1'b0, 1'b1);
		// release below limit minus hysteresis
		write_reg(REG_CURRENT_LIMIT, 10'd1023);
		write_reg(REG_LIMIT_HYSTERESIS, 10'd0);
		send_sample(10'd1023, 1'b1, 1'b1);
		send_sample(10'd1023, 1'b1, 1'b1);
		// smallest limit, set right away
		write_reg(REG_CURRENT_LIMIT, 10'd1);
		write_reg(REG_LIMIT_HYSTERESIS, 10'd1);
		send_sample(10'd1023, 1'b1, 1'b0);
		send_sample(10'd0, 1'b1, 1'b1);
	endtask

	task automatic send_random_stream(int count);
		int level, v, seg_left;
		seg_left = 0;
		level = 0;
		repeat (count) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 32);
				level = $urandom_range(0, 1023);
			end
			seg_left--;
			if ($urandom_range(0, 7) == 0) begin
				v = $urandom_range(0, 1023);
			end else begin
				v = level + int'($urandom_range(0, 64)) - 32;
				if (v < 0) v = 0;
				if (v > 1023) v = 1023;
			end
			send_sample(sample_t'(v), ($urandom_range(0, 7) != 0), ($urandom_range(0, 7) != 0));
		end
	endtask

	task automatic test_random_phases();
		reg_t lim, hys;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin lim = 10'd1023; hys = 10'd0; end
				1: begin lim = 10'd1; hys = 10'd0; end
				2: begin lim = reg_t'($urandom_range(1, 1023)); hys = 10'd1023; end
				3: begin lim = 10'd0; hys = reg_t'($urandom_range(0, 1023)); end
				default: begin
					lim = reg_t'($urandom_range(0, 1023));
					hys = reg_t'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_CURRENT_LIMIT, lim);
			write_reg(REG_LIMIT_HYSTERESIS, hys);
			no_idle = (p == 5);
			send_random_stream(85);
			no_idle = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_off_cycles = 40;
		send_random_stream(40);
		no_idle = 1'b0;
		// sender pause until every result is back
		in_valid <= 1'b0;
		wait_drained();
		send_random_stream(10);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		current_sample = '0;
		enable_a_level = 1'b1;
		enable_b_level = 1'b1;
		wr_en = 1'b0;
		wr_index = REG_CURRENT_LIMIT;
		wr_data = '0;
		foreach (window_ring[i]) window_ring[i] = '0;
		newest_pos = '0;
		running_sum = '0;
		over_limit = 1'b0;
		limit_reg = '0;
		hysteresis_reg = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fault_pins();
		test_limit_directed();
		test_random_phases();
		test_backpressure();

		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("current_avg_limit_monitor_core: match");
		else
			$display("current_avg_limit_monitor_core: mismatch");
		$finish;
	end

	initial begin
		#2ms;
		$display("current_avg_limit_monitor_core: mismatch");
		$finish;
	end

endmodule
